>>> hw/rtl/tsae_pkg.sv
`timescale 1ns / 1ps
package tsae_pkg;

	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_POP   = 4'd1,
		OP_ADD   = 4'd2,
		OP_SUB   = 4'd3,
		OP_MUL   = 4'd4,
		OP_DIV   = 4'd5,
		OP_EQ    = 4'd6,
		OP_NEQ   = 4'd7,
		OP_LOAD  = 4'd8,
		OP_STORE = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		E_NONE  = 3'd0,
		E_UNDER = 3'd1,
		E_TYPE  = 3'd2,
		E_DIVZ  = 3'd3,
		E_INDEX = 3'd4,
		E_OVER  = 3'd5,
		E_CAP   = 3'd6
	} err_t;

	localparam logic [1:0] TAG_NIL  = 2'd0;
	localparam logic [1:0] TAG_INT  = 2'd1;
	localparam logic [1:0] TAG_BOOL = 2'd2;

	// Decoded instruction handed from the front end to the executor
	typedef struct packed {
		logic [3:0]  op;
		logic        known;
		logic [63:0] imm;
		logic [1:0]  tag;
		logic [15:0] gidx;
	} instr_t;

endpackage

>>> hw/rtl/tsae_front.sv
`timescale 1ns / 1ps
module tsae_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [3:0]            req_type,
	input  logic [63:0]           imm_value,
	input  logic                  imm_tag,
	input  logic [15:0]           global_index,
	output logic                  q_valid,
	input  logic                  q_ready,
	output tsae_pkg::instr_t      q_data
);
	import tsae_pkg::*;

	instr_t slot_q [2];
	logic   wr_q, rd_q;
	logic [1:0] cnt_q;
	instr_t dec;

	// Classify: bool immediates collapse to 0/1, undefined codes marked
	always_comb begin
		dec.op    = req_type;
		dec.known = (req_type <= 4'(OP_STORE));
		dec.tag   = imm_tag ? TAG_BOOL : TAG_INT;
		dec.imm   = imm_tag ? {63'd0, |imm_value} : imm_value;
		dec.gidx  = global_index;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = slot_q[rd_q];

	// Two-entry queue
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) slot_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

>>> hw/rtl/tsae_div.sv
`timescale 1ns / 1ps
module tsae_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);
	logic [63:0] rem_q, q_q, d_q;
	logic        neg_q, busy_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;
	logic [63:0] rsh;

	// One quotient bit per cycle, restoring on magnitudes
	assign rsh   = {rem_q[62:0], q_q[63]};
	assign trial = {1'b0, rsh} - {1'b0, d_q};
	assign done  = busy_q && (cnt_q == 7'd0);
	assign quo   = neg_q ? 64'(-q_q) : q_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num[63] ? 64'(-num) : num;
			d_q   <= den[63] ? 64'(-den) : den;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q && cnt_q != 7'd0) begin
			rem_q <= trial[64] ? rsh : trial[63:0];
			q_q   <= {q_q[62:0], ~trial[64]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1; cnt_q <= 7'd64;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 7'd1;
		end
	end
endmodule

>>> hw/rtl/tsae_exec.sv
`timescale 1ns / 1ps
module tsae_exec #(
	parameter int STACK_DEPTH  = 64,
	parameter int GLOBAL_SLOTS = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  tsae_pkg::instr_t q_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             ok,
	output logic [2:0]       error_code,
	output logic [6:0]       stack_count
);
	import tsae_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int GAW = (GLOBAL_SLOTS > 1) ? $clog2(GLOBAL_SLOTS) : 1;
	localparam int GCW = $clog2(GLOBAL_SLOTS + 1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_RD1  = 8'b00000010,
		S_RD2  = 8'b00000100,
		S_ALU  = 8'b00001000,
		S_DIV  = 8'b00010000,
		S_WR   = 8'b00100000,
		S_OUT  = 8'b01000000,
		S_MUL  = 8'b10000000
	} state_t;

	state_t state_q;
	instr_t ins_q;

	logic [63:0] sval_mem [STACK_DEPTH];
	logic [1:0]  stag_mem [STACK_DEPTH];
	logic [63:0] gval_mem [GLOBAL_SLOTS];
	logic [1:0]  gtag_mem [GLOBAL_SLOTS];

	logic [SPW-1:0] sp_q;
	logic [GCW-1:0] gcnt_q;
	logic [63:0] rd_val_q, rv_q, lv_q, res_q;
	logic [1:0]  rd_tag_q, rt_q, res_tag_q;
	logic        ok_q;
	logic [2:0]  err_q;
	logic        div_start, div_done;
	logic [63:0] div_quo;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic        mul_step_q;

	// Stack read address and global-memory address
	logic [SAW-1:0] rd_addr;
	logic [GAW-1:0] gaddr;
	logic           stack_full, gidx_in, gload_ok;

	assign stack_full = (sp_q == SPW'(STACK_DEPTH));
	assign gidx_in    = ({16'd0, ins_q.gidx} < 32'(GLOBAL_SLOTS));
	assign gload_ok   = gidx_in && ({16'd0, ins_q.gidx} < 32'(gcnt_q));
	assign gaddr      = GAW'(ins_q.gidx);
	// Read the top entry, and the entry below it while the first operand is taken
	assign rd_addr    = (state_q == S_RD1) ? SAW'(sp_q - SPW'(2)) : SAW'(sp_q - SPW'(1));

	// Stack memory: one registered read per cycle, one write
	always_ff @(posedge clk) begin
		rd_val_q <= sval_mem[rd_addr];
		rd_tag_q <= stag_mem[rd_addr];
		if (state_q == S_WR && ok_q && res_tag_q != 2'd3 &&
		    !(ins_q.op == 4'(OP_STORE)) && !(ins_q.op == 4'(OP_POP))) begin
			sval_mem[SAW'(sp_q)] <= res_q;
			stag_mem[SAW'(sp_q)] <= res_tag_q;
		end
	end

	// Global memory: registered read, write on store
	logic [63:0] gval_rd_q;
	logic [1:0]  gtag_rd_q;
	logic [GLOBAL_SLOTS-1:0] gvalid_q;
	always_ff @(posedge clk) begin
		gval_rd_q <= gval_mem[gaddr];
		gtag_rd_q <= gtag_mem[gaddr];
		if (state_q == S_WR && ok_q && ins_q.op == 4'(OP_STORE)) begin
			gval_mem[gaddr] <= rv_q;
			gtag_mem[gaddr] <= rt_q;
		end
	end

	tsae_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (lv_q),
		.den   (rv_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Shared 32x32 multiplier: low halves, then the two cross terms
	always_comb begin
		mul_a = lv_q[31:0];
		mul_b = rv_q[31:0];
		if (state_q == S_MUL) begin
			if (mul_step_q) mul_a = lv_q[63:32];
			else mul_b = rv_q[63:32];
		end
	end
	assign mul_p = mul_a * mul_b;

	assign div_start = (state_q == S_ALU) && ins_q.op == 4'(OP_DIV) && ok_q;
	assign q_ready   = (state_q == S_IDLE);

	// Output register
	logic out_valid_q;
	logic [2:0] oerr_q;
	logic ook_q;
	logic [6:0] ocnt_q;
	assign out_valid   = out_valid_q;
	assign ok          = ook_q;
	assign error_code  = oerr_q;
	assign stack_count = ocnt_q;

	// Sequence one instruction: read operands, compute, write back, report
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (q_valid) ins_q <= q_data;
			S_RD1: begin
				rv_q <= rd_val_q; rt_q <= rd_tag_q;
			end
			S_RD2: begin
				lv_q <= rd_val_q;
			end
			S_ALU: begin
				unique case (ins_q.op)
					4'(OP_PUSH): begin res_q <= ins_q.imm; res_tag_q <= ins_q.tag; end
					4'(OP_ADD): begin res_q <= lv_q + rv_q; res_tag_q <= TAG_INT; end
					4'(OP_SUB): begin res_q <= lv_q - rv_q; res_tag_q <= TAG_INT; end
					4'(OP_MUL): begin
						res_q <= mul_p; res_tag_q <= TAG_INT; mul_step_q <= 1'b0;
					end
					4'(OP_EQ):  begin res_q <= {63'd0, lv_q == rv_q}; res_tag_q <= TAG_BOOL; end
					4'(OP_NEQ): begin res_q <= {63'd0, lv_q != rv_q}; res_tag_q <= TAG_BOOL; end
					4'(OP_LOAD): begin
						res_q     <= gvalid_q[gaddr] ? gval_rd_q : 64'd0;
						res_tag_q <= gvalid_q[gaddr] ? gtag_rd_q : TAG_NIL;
					end
					default: begin res_q <= '0; res_tag_q <= TAG_INT; end
				endcase
			end
			// Accumulate a cross term into the upper half
			S_MUL: begin
				res_q[63:32] <= res_q[63:32] + mul_p[31:0];
				mul_step_q   <= 1'b1;
			end
			S_DIV: if (div_done) res_q <= div_quo;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; sp_q <= '0; gcnt_q <= '0; gvalid_q <= '0;
			out_valid_q <= 1'b0; ok_q <= 1'b0; err_q <= E_NONE;
			ook_q <= 1'b0; oerr_q <= '0; ocnt_q <= '0;
		end else begin
			// Raise the status on report, drop it after its transfer
			if (state_q == S_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					ok_q <= 1'b0; err_q <= E_NONE;
					state_q <= S_RD1;
				end
				S_RD1: begin
					// Decide errors that do not depend on operand values
					if (!ins_q.known) state_q <= S_OUT;
					else if (ins_q.op == 4'(OP_PUSH)) begin
						if (stack_full) begin err_q <= E_OVER; state_q <= S_OUT; end
						else begin ok_q <= 1'b1; state_q <= S_ALU; end
					end else if (ins_q.op == 4'(OP_POP)) begin
						if (sp_q == '0) err_q <= E_UNDER;
						else begin ok_q <= 1'b1; sp_q <= sp_q - SPW'(1); end
						state_q <= S_OUT;
					end else if (ins_q.op == 4'(OP_LOAD)) begin
						if (!gload_ok) begin err_q <= E_INDEX; state_q <= S_OUT; end
						else if (stack_full) begin err_q <= E_OVER; state_q <= S_OUT; end
						else begin ok_q <= 1'b1; state_q <= S_ALU; end
					end else if (ins_q.op == 4'(OP_STORE)) begin
						if (sp_q == '0) begin err_q <= E_UNDER; state_q <= S_OUT; end
						else begin
							sp_q <= sp_q - SPW'(1);
							if (!gidx_in) begin err_q <= E_CAP; state_q <= S_OUT; end
							else begin ok_q <= 1'b1; state_q <= S_WR; end
						end
					end else begin
						if (sp_q < SPW'(2)) begin
							sp_q <= '0; err_q <= E_UNDER; state_q <= S_OUT;
						end else begin
							sp_q <= sp_q - SPW'(1); state_q <= S_RD2;
						end
					end
				end
				S_RD2: begin
					// Second operand read issued; check tags and a zero divisor
					sp_q <= sp_q - SPW'(1);
					if (ins_q.op <= 4'(OP_DIV)) begin
						if (rt_q != TAG_INT || rd_tag_q != TAG_INT) begin
							err_q <= E_TYPE; state_q <= S_OUT;
						end else if (ins_q.op == 4'(OP_DIV) && rv_q == 64'd0) begin
							err_q <= E_DIVZ; state_q <= S_OUT;
						end else begin
							ok_q <= 1'b1; state_q <= S_ALU;
						end
					end else begin
						if (rt_q != rd_tag_q || rd_tag_q == TAG_NIL) begin
							err_q <= E_TYPE; state_q <= S_OUT;
						end else begin
							ok_q <= 1'b1; state_q <= S_ALU;
						end
					end
				end
				S_ALU: begin
					if (ins_q.op == 4'(OP_DIV)) state_q <= S_DIV;
					else if (ins_q.op == 4'(OP_MUL)) state_q <= S_MUL;
					else state_q <= S_WR;
				end
				S_MUL: if (mul_step_q) state_q <= S_WR;
				S_DIV: if (div_done) state_q <= S_WR;
				S_WR: begin
					if (ins_q.op == 4'(OP_STORE)) begin
						gvalid_q[gaddr] <= 1'b1;
						if ({16'd0, ins_q.gidx} >= 32'(gcnt_q))
							gcnt_q <= GCW'(ins_q.gidx) + GCW'(1);
					end else sp_q <= sp_q + SPW'(1);
					state_q <= S_OUT;
				end
				S_OUT: if (!out_valid_q || out_ready) begin
					ook_q  <= ok_q;
					oerr_q <= err_q;
					ocnt_q <= 7'(sp_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/typed_stack_alu_executor.sv
`timescale 1ns / 1ps
// Stack-machine executor: one instruction per input transfer, one status
// transfer out. Each instruction steps through the idle, operand-read, ALU,
// write and report states that it needs; mul makes three passes through a
// 32x32 multiplier and div waits on the one-bit-per-cycle divider. Errors
// found early finish sooner. The two-entry queue in front registers each
// instruction, and the executor takes the next one only when idle. A stalled
// output holds the executor in its report state, after which the queue fills
// and the input stalls. No clearing pass after reset.
module typed_stack_alu_executor #(
	parameter int STACK_DEPTH  = 64,
	parameter int GLOBAL_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // req_type[3:0], imm_value[67:4], imm_tag[68], global_index[84:69]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // ok[0], error_code[3:1], stack_count[10:4]
);
	import tsae_pkg::*;

	logic   q_valid, q_ready;
	instr_t q_data;
	logic   ok;
	logic [2:0] ec;
	logic [6:0] sc;

	tsae_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.req_type(s_tdata[3:0]), .imm_value(s_tdata[67:4]),
		.imm_tag(s_tdata[68]), .global_index(s_tdata[84:69]),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	tsae_exec #(.STACK_DEPTH(STACK_DEPTH), .GLOBAL_SLOTS(GLOBAL_SLOTS)) u_exec (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.ok(ok), .error_code(ec), .stack_count(sc)
	);

	assign m_tdata = {5'd0, sc, ec, ok};
endmodule

>>> hw/rtl/tsae_checker.sv
`timescale 1ns / 1ps
module tsae_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");
	a_okerr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[3:1] == 3'd0) else $error("ok with error");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:1] != 3'd7) else $error("bad code");
endmodule

bind typed_stack_alu_executor tsae_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
